### src/bavs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bounded aging value stack.
// No dependencies; imported by the RAM and the top level.
package bavs_pkg;

  localparam int DATA_W  = 32;
  localparam int SIZE_W  = 5;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_TICK  = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_SIZE = 2'd0,
    REG_MAX_AGE  = 2'd1,
    REG_SPARE_2  = 2'd2,
    REG_SPARE_3  = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TRIM,
    S_CHK_RD,
    S_CHK,
    S_INSERT,
    S_POP_RD,
    S_POP,
    S_AGE,
    S_RESP
  } state_t;

  localparam logic [DATA_W-1:0] AGE_SAT = '1;

endpackage

### src/bavs_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// Uses bavs_pkg only for the house import convention.
module bavs_ram
  import bavs_pkg::*;
#(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]               wdata,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/bounded_aging_value_stack.sv
`timescale 1ns / 1ps
// Top level of the bounded aging value stack: sequencer, pointers, result register.
// Depends on bavs_pkg and two bavs_ram instances (values and ages).
//
// A LIFO of up to DEPTH signed 32-bit words, each with a saturating age. Each input
// word (push, pop, clear, tick) yields one result word. One item is worked at a time
// by a small sequencer around a value RAM and an age RAM with registered reads; in_ready
// is high only while the sequencer is idle. A clear, or a pop of an empty stack, goes
// straight to the result; a tick does one age read-increment-write per cycle,
// pipelined through the age RAM port; a push first drops expired bottom entries,
// checking one entry at a time, then writes the new word.
// A waiting result does not block the next input word, only the following result.
module bounded_aging_value_stack
  import bavs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           action,
  input  logic signed [31:0]   value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   pop_value,
  output logic                 pop_ok,
  output logic [4:0]           count,
  output logic                 is_empty,
  output logic                 is_full,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] b, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(b) + (CW+1)'(off);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[PW-1:0];
  endfunction

  state_t state, state_next;

  logic [SIZE_W-1:0] max_size;
  logic [DATA_W-1:0] max_age;
  logic [PW-1:0]     bottom;
  logic [CW-1:0]     cnt;
  logic [DATA_W-1:0] cur_value;
  logic [DATA_W-1:0] res_value;
  logic              res_ok;
  logic [CW-1:0]     age_idx;
  logic              age_pend;
  logic [PW-1:0]     age_addr;

  logic [CW-1:0]     lim;
  logic              in_fire;
  logic              out_load;
  action_t           act;

  logic              ram_val_we;
  logic              ram_age_we;
  logic [PW-1:0]     ram_waddr;
  logic [PW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_age_wdata;
  logic [DATA_W-1:0] val_rdata;
  logic [DATA_W-1:0] age_rdata;
  logic [DATA_W-1:0] age_inc;

  assign act       = action_t'(action);
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_load  = (state == S_RESP) && (!out_valid || out_ready);
  assign age_inc   = (age_rdata == AGE_SAT) ? age_rdata : age_rdata + 1'b1;

  always_comb begin
    if (max_size == '0) begin
      lim = CW'(1);
    end else if (32'(max_size) > 32'(DEPTH)) begin
      lim = CW'(DEPTH);
    end else begin
      lim = CW'(max_size);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (act)
            ACT_PUSH:  state_next = S_TRIM;
            ACT_POP:   state_next = (cnt == '0) ? S_RESP : S_POP_RD;
            ACT_CLEAR: state_next = S_RESP;
            ACT_TICK:  state_next = S_AGE;
            default:   state_next = S_RESP;
          endcase
        end
      end
      S_TRIM:   state_next = S_CHK_RD;
      S_CHK_RD: state_next = (cnt == '0) ? S_INSERT : S_CHK;
      S_CHK:    state_next = (age_rdata > max_age) ? S_CHK_RD : S_INSERT;
      S_INSERT: state_next = S_RESP;
      S_POP_RD: state_next = S_POP;
      S_POP:    state_next = S_RESP;
      S_AGE: begin
        if (!age_pend && !(age_idx < cnt)) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // RAM controls
  always_comb begin
    ram_val_we    = 1'b0;
    ram_age_we    = 1'b0;
    ram_waddr     = wrap_add(bottom, cnt);
    ram_raddr     = bottom;
    ram_age_wdata = '0;
    case (state)
      S_INSERT: begin
        ram_val_we = 1'b1;
        ram_age_we = 1'b1;
      end
      S_POP_RD: begin
        ram_raddr = wrap_add(bottom, cnt - 1'b1);
      end
      S_AGE: begin
        ram_age_we    = age_pend;
        ram_waddr     = age_addr;
        ram_age_wdata = age_inc;
        ram_raddr     = wrap_add(bottom, age_idx);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      max_size <= SIZE_W'(16);
      max_age  <= DATA_W'(1000);
      bottom   <= '0;
      cnt      <= '0;
      age_pend <= 1'b0;
      age_idx  <= '0;
      res_ok   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_MAX_SIZE: max_size <= cfg_data[SIZE_W-1:0];
          REG_MAX_AGE:  max_age  <= cfg_data;
          default: begin
          end
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            res_ok   <= 1'b0;
            age_idx  <= '0;
            age_pend <= 1'b0;
            if (act == ACT_CLEAR) begin
              cnt    <= '0;
              bottom <= '0;
            end
          end
        end
        S_TRIM: begin
          if (cnt > lim) begin
            bottom <= wrap_add(bottom, cnt - lim);
            cnt    <= lim;
          end
        end
        S_CHK: begin
          if (age_rdata > max_age) begin
            bottom <= wrap_add(bottom, CW'(1));
            cnt    <= cnt - 1'b1;
          end
        end
        S_INSERT: begin
          if (cnt >= lim) begin
            bottom <= wrap_add(bottom, CW'(1));
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_POP: begin
          res_ok <= 1'b1;
          cnt    <= cnt - 1'b1;
        end
        S_AGE: begin
          if (age_idx < cnt) begin
            age_pend <= 1'b1;
            age_idx  <= age_idx + 1'b1;
          end else begin
            age_pend <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_value <= value;
      res_value <= '0;
    end
    if (state == S_POP) begin
      res_value <= val_rdata;
    end
    if (state == S_AGE) begin
      age_addr <= ram_raddr;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pop_value <= res_value;
      pop_ok    <= res_ok;
      count     <= SIZE_W'(cnt);
      is_empty  <= (cnt == '0);
      is_full   <= (cnt >= lim);
    end
  end

  bavs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_val_ram (
    .clk   (clk),
    .we    (ram_val_we),
    .waddr (ram_waddr),
    .wdata (cur_value),
    .raddr (ram_raddr),
    .rdata (val_rdata)
  );

  bavs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_age_ram (
    .clk   (clk),
    .we    (ram_age_we),
    .waddr (ram_waddr),
    .wdata (ram_age_wdata),
    .raddr (ram_raddr),
    .rdata (age_rdata)
  );

endmodule
